/* hdl/pnf_pkg.sv */
`timescale 1ns / 1ps
package pnf_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int ENTRY_W = 8;
    localparam int COORD_W = 32;
    localparam int NOISE_W = 18;
    localparam int OCT_W = 5;
    localparam logic [OCT_W-1:0] OCT_RESET = 5'd4;
    localparam logic [OCT_W-1:0] MAX_OCT = 5'd16;

    // base frequency 0.1 as 6554/65536, and unit scale for single noise
    localparam logic signed [18:0] FREQ_BASE = 19'sd6554;
    localparam logic signed [18:0] FREQ_UNIT = 19'sd65536;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_NOISE = 2'd1,
        FUNC_FBM   = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMUL,
        ST_OCT,
        ST_NOISE,
        ST_ACC,
        ST_FMUL,
        ST_OUT
    } state_t;

    // 6t^2 - 15t + 10, rounded to Q16
    function automatic logic [19:0] fade_poly(input logic [31:0] t2, input logic [15:0] t);
        logic [36:0] poly;
        poly = 37'(t2) * 37'd6 + (37'd10 << 32) - ((37'(t) * 37'd15) << 16) + 37'd32768;
        return poly[35:16];
    endfunction

    function automatic logic signed [18:0] grad_fn(input logic [3:0] h,
                                                   input logic signed [17:0] x,
                                                   input logic signed [17:0] y,
                                                   input logic signed [17:0] z);
        logic signed [17:0] ga;
        logic signed [17:0] gb;
        ga = (h < 4'd8) ? x : y;
        if (h < 4'd4) begin
            gb = y;
        end else if (h == 4'd12 || h == 4'd14) begin
            gb = x;
        end else begin
            gb = z;
        end
        return (h[0] ? -19'(ga) : 19'(ga)) + (h[1] ? -19'(gb) : 19'(gb));
    endfunction

    // round(2^32 / (2^16 - 2^(16-n)))
    function automatic logic [17:0] recip_lut(input logic [OCT_W-1:0] n);
        logic [17:0] r;
        case (n)
            5'd1:    r = 18'd131072;
            5'd2:    r = 18'd87381;
            5'd3:    r = 18'd74898;
            5'd4:    r = 18'd69905;
            5'd5:    r = 18'd67650;
            5'd6:    r = 18'd66576;
            5'd7:    r = 18'd66052;
            5'd8:    r = 18'd65793;
            5'd9:    r = 18'd65664;
            5'd10:   r = 18'd65600;
            5'd11:   r = 18'd65568;
            5'd12:   r = 18'd65552;
            5'd13:   r = 18'd65544;
            5'd14:   r = 18'd65540;
            5'd15:   r = 18'd65538;
            5'd16:   r = 18'd65537;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

    function automatic logic signed [NOISE_W-1:0] sat18(input logic signed [23:0] v);
        logic signed [NOISE_W-1:0] r;
        if (v > 24'sd131071) begin
            r = 18'sd131071;
        end else if (v < -24'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[NOISE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/perlin_noise_3d_fbm.sv */
`timescale 1ns / 1ps
// 3d gradient noise and fbm evaluator with a loadable permutation table
// input channel (s_*): s_func selects load entry, single noise or fbm.
//   a load request writes one table entry in the cycle it is accepted and
//   gives no result; every entry must be loaded before any noise request.
//   noise and fbm requests take signed q16.16 coordinates.
// result channel (m_*): one q2.16 value per noise or fbm request.
// cfg channel: octave count for fbm, always ready, write only while idle.
// one request is processed at a time; the table memory port and the shared
// multiplier are used by one step each cycle. fbm runs one noise pass per
// octave. the block returns to idle as the result is registered and takes
// the next request from there.
// the result sits in an output register, so a new request is accepted while
// the previous result waits; a finished result waits in the last state
// until the output register is free, so a stalled receiver holds the block.
// reset clears control state and sets the octave count to 4; table
// contents are undefined after reset.
module perlin_noise_3d_fbm #(
    parameter int TABLE_SIZE = pnf_pkg::TABLE_SIZE_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_func,
    input  logic signed [pnf_pkg::COORD_W-1:0]     s_coord_x,
    input  logic signed [pnf_pkg::COORD_W-1:0]     s_coord_y,
    input  logic signed [pnf_pkg::COORD_W-1:0]     s_coord_z,
    input  logic [pnf_pkg::ENTRY_W-1:0]            s_entry_index,
    input  logic [pnf_pkg::ENTRY_W-1:0]            s_entry_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pnf_pkg::NOISE_W-1:0]     m_noise_value,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pnf_pkg::OCT_W-1:0]              cfg_data
);

    import pnf_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);

    state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;

    logic                    fbm_reg;
    logic [OCT_W-1:0]        oct_cfg_reg;
    logic [3:0]              oct_reg;
    logic [OCT_W-1:0]        oct_num;
    logic                    oct_last;

    logic signed [COORD_W-1:0] c_reg [3];
    logic signed [47:0]        p_reg [3];
    logic [15:0]               f_reg [3];
    logic [IW-1:0]             i_reg [3];
    logic [31:0]               t2_reg [3];
    logic [16:0]               t3_reg [3];
    logic [16:0]               fd_reg [3];

    logic [IW-1:0] a_reg, b_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic [3:0]    h_reg [8];

    logic signed [18:0] lp_reg [6];
    logic signed [18:0] noise_reg;
    logic signed [35:0] acc_reg;
    logic [35:0]        lo_reg;
    logic signed [NOISE_W-1:0] res_reg;
    logic signed [NOISE_W-1:0] m_noise_reg;
    logic                      m_valid_reg;

    logic signed [32:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [51:0] prod_reg;

    logic               ram_we;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [IW-1:0]      d_idx;
    logic               load_ok;
    logic               s_take;

    logic signed [17:0] lo_c [3];
    logic signed [17:0] hi_c [3];
    logic signed [18:0] g [8];
    logic signed [18:0] lerp_base;
    logic signed [18:0] lerp_res;
    logic [16:0]        t3_c;
    logic [36:0]        frnd;
    logic [16:0]        fcap;
    logic [17:0]        recip;
    logic signed [55:0] fin_total;

    pnf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_perm (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (IW'(s_entry_index)),
        .wr_data (s_entry_value),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_take  = s_valid && s_ready;
    assign load_ok = (32'(s_entry_index) < TABLE_SIZE);
    assign ram_we  = s_take && (s_func == FUNC_LOAD) && load_ok;
    assign d_idx   = IW'(ram_rdata);
    assign cfg_ready = 1'b1;

    assign oct_num = (oct_cfg_reg == 5'd0) ? 5'd1 :
                     (oct_cfg_reg > MAX_OCT) ? MAX_OCT : oct_cfg_reg;
    assign oct_last = ((5'(oct_reg) + 5'd1) == oct_num);
    assign recip = recip_lut(oct_num);

    // corner offsets: fraction and fraction minus one
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lo_c[k] = {2'b00, f_reg[k]};
            hi_c[k] = {2'b11, f_reg[k]};
        end
        for (int k = 0; k < 8; k++) begin
            g[k] = grad_fn(h_reg[k],
                           k[2] ? hi_c[0] : lo_c[0],
                           k[1] ? hi_c[1] : lo_c[1],
                           k[0] ? hi_c[2] : lo_c[2]);
        end
    end

    assign t3_c = 17'((prod_reg[47:0] + 48'd2147483648) >> 32);
    assign frnd = prod_reg[36:0] + 37'd32768;
    assign fcap = (frnd[36:16] > 21'd65536) ? 17'd65536 : frnd[32:16];

    always_comb begin
        case (step_reg)
            5'd13:   lerp_base = g[0];
            5'd14:   lerp_base = g[1];
            5'd15:   lerp_base = g[2];
            5'd16:   lerp_base = g[3];
            5'd17:   lerp_base = lp_reg[0];
            5'd18:   lerp_base = lp_reg[2];
            default: lerp_base = lp_reg[4];
        endcase
    end
    assign lerp_res = lerp_base + 19'((prod_reg + 52'sd32768) >>> 16);

    assign fin_total = (56'(prod_reg) <<< 18) + 56'(lo_reg) + (56'sd1 <<< 31);

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = 5'd0;
                if (s_valid && (s_func == FUNC_NOISE || s_func == FUNC_FBM)) begin
                    state_next = ST_CMUL;
                end
            end
            ST_CMUL: begin
                if (step_reg == 5'd3) begin
                    state_next = ST_OCT;
                    step_next  = 5'd0;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_OCT: begin
                state_next = ST_NOISE;
                step_next  = 5'd0;
            end
            ST_NOISE: begin
                if (step_reg == 5'd20) begin
                    state_next = ST_ACC;
                    step_next  = 5'd0;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_ACC: begin
                if (!fbm_reg) begin
                    state_next = ST_OUT;
                end else if (oct_last) begin
                    state_next = ST_FMUL;
                end else begin
                    state_next = ST_OCT;
                end
            end
            ST_FMUL: begin
                if (step_reg == 5'd2) begin
                    state_next = ST_OUT;
                    step_next  = 5'd0;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = 5'd0;
            end
        endcase
    end

    // outputs: handshake, multiplier operands, table read address
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        mul_a     = '0;
        mul_b     = '0;
        ram_raddr = i_reg[0];
        case (state_reg)
            ST_CMUL: begin
                mul_b = fbm_reg ? FREQ_BASE : FREQ_UNIT;
                case (step_reg)
                    5'd0:    mul_a = 33'(c_reg[0]);
                    5'd1:    mul_a = 33'(c_reg[1]);
                    5'd2:    mul_a = 33'(c_reg[2]);
                    default: mul_b = '0;
                endcase
            end
            ST_NOISE: begin
                case (step_reg)
                    5'd0: begin mul_a = 33'(f_reg[0]); mul_b = 19'(f_reg[0]); end
                    5'd1: begin mul_a = 33'(f_reg[1]); mul_b = 19'(f_reg[1]); end
                    5'd2: begin mul_a = 33'(f_reg[2]); mul_b = 19'(f_reg[2]); end
                    5'd3: begin mul_a = 33'(t2_reg[0]); mul_b = 19'(f_reg[0]); end
                    5'd4: begin mul_a = 33'(t2_reg[1]); mul_b = 19'(f_reg[1]); end
                    5'd5: begin mul_a = 33'(t2_reg[2]); mul_b = 19'(f_reg[2]); end
                    5'd6: begin
                        mul_a = 33'(fade_poly(t2_reg[0], f_reg[0]));
                        mul_b = 19'(t3_reg[0]);
                    end
                    5'd7: begin
                        mul_a = 33'(fade_poly(t2_reg[1], f_reg[1]));
                        mul_b = 19'(t3_reg[1]);
                    end
                    5'd8: begin
                        mul_a = 33'(fade_poly(t2_reg[2], f_reg[2]));
                        mul_b = 19'(t3_reg[2]);
                    end
                    5'd12: begin mul_a = 33'(g[4] - g[0]); mul_b = 19'(fd_reg[0]); end
                    5'd13: begin mul_a = 33'(g[5] - g[1]); mul_b = 19'(fd_reg[0]); end
                    5'd14: begin mul_a = 33'(g[6] - g[2]); mul_b = 19'(fd_reg[0]); end
                    5'd15: begin mul_a = 33'(g[7] - g[3]); mul_b = 19'(fd_reg[0]); end
                    5'd16: begin
                        mul_a = 33'(lp_reg[1] - lp_reg[0]);
                        mul_b = 19'(fd_reg[1]);
                    end
                    5'd17: begin
                        mul_a = 33'(lp_reg[3] - lp_reg[2]);
                        mul_b = 19'(fd_reg[1]);
                    end
                    5'd19: begin
                        mul_a = 33'(lp_reg[5] - lp_reg[4]);
                        mul_b = 19'(fd_reg[2]);
                    end
                    default: mul_a = '0;
                endcase
                // hash chain: later read addresses come from earlier reads
                case (step_reg)
                    5'd1:    ram_raddr = i_reg[0] + IW'(1);
                    5'd2:    ram_raddr = a_reg;
                    5'd3:    ram_raddr = a_reg + IW'(1);
                    5'd4:    ram_raddr = b_reg;
                    5'd5:    ram_raddr = b_reg + IW'(1);
                    5'd6:    ram_raddr = aa_reg;
                    5'd7:    ram_raddr = aa_reg + IW'(1);
                    5'd8:    ram_raddr = ab_reg;
                    5'd9:    ram_raddr = ab_reg + IW'(1);
                    5'd10:   ram_raddr = ba_reg;
                    5'd11:   ram_raddr = ba_reg + IW'(1);
                    5'd12:   ram_raddr = bb_reg;
                    5'd13:   ram_raddr = bb_reg + IW'(1);
                    default: ram_raddr = i_reg[0];
                endcase
            end
            ST_FMUL: begin
                mul_b = 19'(recip);
                case (step_reg)
                    5'd0:    mul_a = 33'(acc_reg[17:0]);
                    5'd1:    mul_a = 33'($signed(acc_reg[35:18]));
                    default: mul_b = '0;
                endcase
            end
            default: mul_a = '0;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= 5'd0;
            oct_cfg_reg <= OCT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_valid && cfg_ready) begin
                oct_cfg_reg <= cfg_data;
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        logic signed [63:0] sh;
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_noise_reg <= res_reg;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    fbm_reg  <= (s_func == FUNC_FBM);
                    c_reg[0] <= s_coord_x;
                    c_reg[1] <= s_coord_y;
                    c_reg[2] <= s_coord_z;
                    oct_reg  <= 4'd0;
                    acc_reg  <= '0;
                end
            end
            ST_CMUL: begin
                case (step_reg)
                    5'd1:    p_reg[0] <= prod_reg[47:0];
                    5'd2:    p_reg[1] <= prod_reg[47:0];
                    5'd3:    p_reg[2] <= prod_reg[47:0];
                    default: p_reg[0] <= p_reg[0];
                endcase
            end
            ST_OCT: begin
                for (int k = 0; k < 3; k++) begin
                    sh = 64'(p_reg[k]) <<< oct_reg;
                    f_reg[k] <= sh[31:16];
                    i_reg[k] <= sh[32 +: IW];
                end
            end
            ST_NOISE: begin
                case (step_reg)
                    5'd1: begin t2_reg[0] <= prod_reg[31:0]; a_reg <= d_idx + i_reg[1]; end
                    5'd2: begin t2_reg[1] <= prod_reg[31:0]; b_reg <= d_idx + i_reg[1]; end
                    5'd3: begin t2_reg[2] <= prod_reg[31:0]; aa_reg <= d_idx + i_reg[2]; end
                    5'd4: begin t3_reg[0] <= t3_c; ab_reg <= d_idx + i_reg[2]; end
                    5'd5: begin t3_reg[1] <= t3_c; ba_reg <= d_idx + i_reg[2]; end
                    5'd6: begin t3_reg[2] <= t3_c; bb_reg <= d_idx + i_reg[2]; end
                    5'd7: begin fd_reg[0] <= fcap; h_reg[0] <= ram_rdata[3:0]; end
                    5'd8: begin fd_reg[1] <= fcap; h_reg[1] <= ram_rdata[3:0]; end
                    5'd9: begin fd_reg[2] <= fcap; h_reg[2] <= ram_rdata[3:0]; end
                    5'd10: h_reg[3] <= ram_rdata[3:0];
                    5'd11: h_reg[4] <= ram_rdata[3:0];
                    5'd12: h_reg[5] <= ram_rdata[3:0];
                    5'd13: begin h_reg[6] <= ram_rdata[3:0]; lp_reg[0] <= lerp_res; end
                    5'd14: begin h_reg[7] <= ram_rdata[3:0]; lp_reg[2] <= lerp_res; end
                    5'd15: lp_reg[1] <= lerp_res;
                    5'd16: lp_reg[3] <= lerp_res;
                    5'd17: lp_reg[4] <= lerp_res;
                    5'd18: lp_reg[5] <= lerp_res;
                    5'd20: noise_reg <= lerp_res;
                    default: noise_reg <= noise_reg;
                endcase
            end
            ST_ACC: begin
                acc_reg <= acc_reg + (36'(noise_reg) <<< (4'd15 - oct_reg));
                oct_reg <= oct_reg + 4'd1;
                res_reg <= sat18(24'(noise_reg));
            end
            ST_FMUL: begin
                case (step_reg)
                    5'd1:    lo_reg <= prod_reg[35:0];
                    5'd2:    res_reg <= sat18(fin_total[55:32]);
                    default: lo_reg <= lo_reg;
                endcase
            end
            default: res_reg <= res_reg;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_noise_value = m_noise_reg;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == ST_IDLE)
        else $error("table write outside idle");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=>
            (state_reg == ST_OUT && m_valid_reg))
        else $error("pending result overwritten");

    a_fade_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NOISE && step_reg == 5'd12) |->
            (fd_reg[0] <= 17'd65536 && fd_reg[1] <= 17'd65536 && fd_reg[2] <= 17'd65536))
        else $error("fade above one");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_take && (s_func == FUNC_NOISE || s_func == FUNC_FBM)) |=>
            (state_reg == ST_CMUL && !s_ready))
        else $error("noise request did not start");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC && !fbm_reg) |=> state_reg == ST_OUT)
        else $error("single noise ran extra octaves");
`endif

endmodule

/* hdl/pnf_ram.sv */
`timescale 1ns / 1ps
module pnf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
